FILE: design/xmodem_batch_block_sender_core_assert.svh
// Assertion macros shared by the XMODEM sender modules.
`ifndef XMODEM_BATCH_BLOCK_SENDER_CORE_ASSERT_SVH
`define XMODEM_BATCH_BLOCK_SENDER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define XBS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication checked on the next clock edge.
`define XBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/xbs_pkg.sv
// Package with types, codes and constants of the XMODEM block sender.
package xbs_pkg;
   localparam int BlockBytesDefault = 128;
   localparam logic [7:0] ChSoh = 8'h01;
   localparam logic [7:0] ChEot = 8'h04;
   localparam logic [7:0] ChAck = 8'h06;
   localparam logic [7:0] ChNak = 8'h15;
   localparam logic [7:0] ChCan = 8'h18;
   localparam logic [7:0] ChWantCrc = 8'h43;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      CMD_BEGIN = 3'd0, CMD_LOAD = 3'd1, CMD_SEND_BLOCK = 3'd2, CMD_SEND_EOT = 3'd3,
      CMD_TX_READY = 3'd4, CMD_RX_BYTE = 3'd5, CMD_TICK = 3'd6, CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      REG_BLOCK_RETRY = 3'd0, REG_EOT_LIMIT = 3'd1, REG_START_WAIT = 3'd2,
      REG_REPLY_WAIT = 3'd3, REG_DRAIN_WAIT = 3'd4
   } reg_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_ANY, PH_START_NAK, PH_SENDING, PH_REPLY, PH_DRAIN,
      PH_EOT_SEND, PH_EOT_WAIT, PH_CANCEL, PH_DONE, PH_FAILED
   } phase_type;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StStart = 3'd1;
   localparam logic [2:0] StSending = 3'd2;
   localparam logic [2:0] StReply = 3'd3;
   localparam logic [2:0] StDone = 3'd4;
   localparam logic [2:0] StFailed = 3'd5;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] byte_in;
      logic [7:0] block_number;
      logic [1:0] wait_mode;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [2:0] status;
      logic       crc_mode;
   } rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      cmd_type    cmd;
      logic       is_ack;
      logic       is_can;
      logic       is_nak;
      logic       is_want_crc;
      logic [7:0] byte_in;
      logic [7:0] block_number;
      logic [1:0] wait_mode;
   } op_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic [7:0] bits;
      logic top;
      c = crc;
      bits = b;
      for (int k = 0; k < 8; k++) begin
         top = c[15];
         c = {c[14:0], bits[7]};
         bits = {bits[6:0], 1'b0};
         if (top) c = c ^ CrcPoly;
      end
      return c;
   endfunction
endpackage

FILE: design/xbs_front.sv
// Front part: accepts request items, classifies them and queues them.
module xbs_front import xbs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    op_valid,
   input  logic    op_take,
   output op_type  op_data
);
   `include "xmodem_batch_block_sender_core_assert.svh"
   op_type q_ff [QueueDepth];
   logic [1:0] count_ff, count_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push, pop;
   op_type cls;

   always_comb begin
      cls.cmd = cmd_type'(req_data.command);
      cls.is_ack = (req_data.byte_in == ChAck);
      cls.is_can = (req_data.byte_in == ChCan);
      cls.is_nak = (req_data.byte_in == ChNak);
      cls.is_want_crc = (req_data.byte_in == ChWantCrc);
      cls.byte_in = req_data.byte_in;
      cls.block_number = req_data.block_number;
      cls.wait_mode = req_data.wait_mode;
   end

   assign req_stall = (count_ff == 2'(QueueDepth));
   assign push = req_valid && !req_stall;
   assign op_valid = (count_ff != 2'd0);
   assign pop = op_valid && op_take;
   assign op_data = q_ff[rd_ff];

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end

   `XBS_ASSERT_IMPL(a_no_overflow, clock, reset, count_ff == 2'(QueueDepth), !push,
      "queue push while full")
   `XBS_ASSERT_NEXT(a_count_step, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1,
      "queue count did not grow")
   `XBS_ASSERT_IMPL(a_ptr_match, clock, reset, count_ff == 2'd0, rd_ff == wr_ff,
      "queue pointers disagree when empty")
endmodule

FILE: design/xbs_back.sv
// Back part: protocol sequencer, block store and result register.
module xbs_back import xbs_pkg::*; #(
   parameter int BLOCK_BYTES = BlockBytesDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic    op_valid,
   output logic    op_take,
   input  op_type  op_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   `include "xmodem_batch_block_sender_core_assert.svh"
   localparam int AW = $clog2(BLOCK_BYTES);
   localparam int PW = $clog2(BLOCK_BYTES + 6);
   localparam logic [PW-1:0] DataEnd = PW'(BLOCK_BYTES + 3);

   logic [7:0] store [BLOCK_BYTES];
   logic [7:0] rd_ff;
   logic [3:0] retry_lim_ff, eot_lim_ff;
   logic [15:0] start_w_ff, reply_w_ff, drain_w_ff;
   phase_type ph_ff, ph_in;
   logic [AW-1:0] load_ff, load_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in, timer_ff, timer_in;
   logic [7:0] sum_ff, sum_in, num_ff, num_in;
   logic usecrc_ff, usecrc_in, first_ff, first_in, pcan_ff, pcan_in;
   logic [3:0] att_ff, att_in;
   logic [1:0] canl_ff, canl_in;
   logic txv;
   logic [7:0] txb;
   logic [15:0] crc_tail;
   logic go, free_now;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff;
   logic [PW-1:0] nxt_pos, off;

   assign op_take = !rv_ff || !rsp_stall;
   assign go = op_valid && op_take;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign free_now = (ph_ff == PH_IDLE) || (ph_ff == PH_DONE) || (ph_ff == PH_FAILED);

   // The store is read into a register at the send offset of the next cycle.
   assign nxt_pos = go ? pos_in : pos_ff;
   assign off = nxt_pos - PW'(3);
   assign crc_tail = crc_feed(crc_feed(crc_ff, 8'd0), 8'd0);

   always_comb begin
      ph_in = ph_ff; load_in = load_ff; pos_in = pos_ff; crc_in = crc_ff;
      sum_in = sum_ff; num_in = num_ff; usecrc_in = usecrc_ff; first_in = first_ff;
      pcan_in = pcan_ff; att_in = att_ff; canl_in = canl_ff; timer_in = timer_ff;
      txv = 1'b0; txb = 8'd0;
      unique case (op_data.cmd)
         CMD_BEGIN: begin
            usecrc_in = 1'b0; first_in = 1'b1; ph_in = PH_IDLE; canl_in = 2'd0;
         end
         CMD_LOAD: load_in = (load_ff == AW'(BLOCK_BYTES - 1)) ? '0 : load_ff + AW'(1);
         CMD_SEND_BLOCK: if (free_now) begin
            num_in = op_data.block_number; att_in = 4'd0; load_in = '0;
            if (op_data.wait_mode == 2'd1) begin
               ph_in = PH_START_ANY; timer_in = start_w_ff;
            end else if (op_data.wait_mode == 2'd2) begin
               first_in = 1'b1; ph_in = PH_START_NAK; timer_in = start_w_ff;
            end else begin
               pos_in = '0; pcan_in = 1'b0; ph_in = PH_SENDING;
            end
         end
         CMD_SEND_EOT: if (free_now) begin
            att_in = 4'd0; ph_in = PH_EOT_SEND;
         end
         CMD_TX_READY: begin
            if (ph_ff == PH_SENDING) begin
               txv = 1'b1;
               if (pos_ff == '0) begin
                  crc_in = '0; sum_in = '0; txb = ChSoh;
               end else if (pos_ff == PW'(1)) txb = num_ff;
               else if (pos_ff == PW'(2)) txb = ~num_ff;
               else if (pos_ff < DataEnd) begin
                  txb = rd_ff;
                  crc_in = crc_feed(crc_ff, rd_ff);
                  sum_in = sum_ff + rd_ff;
               end else if (usecrc_ff && pos_ff == DataEnd) begin
                  crc_in = crc_tail; txb = crc_tail[15:8];
               end else if (usecrc_ff) txb = crc_ff[7:0];
               else txb = sum_ff;
               pos_in = pos_ff + PW'(1);
               if (pos_in >= DataEnd + (usecrc_ff ? PW'(2) : PW'(1))) begin
                  ph_in = PH_REPLY; timer_in = reply_w_ff;
               end
            end else if (ph_ff == PH_EOT_SEND) begin
               txv = 1'b1; txb = ChEot;
               if (att_ff != 4'hF) att_in = att_ff + 4'd1;
               ph_in = PH_EOT_WAIT; timer_in = reply_w_ff;
            end else if (ph_ff == PH_CANCEL) begin
               txv = 1'b1; txb = ChCan;
               if (canl_ff <= 2'd1) begin
                  canl_in = 2'd0; ph_in = PH_FAILED;
               end else canl_in = canl_ff - 2'd1;
            end
         end
         CMD_RX_BYTE: begin
            if (ph_ff == PH_START_ANY) begin
               if (op_data.is_want_crc) usecrc_in = 1'b1;
               pos_in = '0; pcan_in = 1'b0; ph_in = PH_SENDING;
            end else if (ph_ff == PH_START_NAK) begin
               if (op_data.is_can) begin
                  canl_in = 2'd3; ph_in = PH_CANCEL;
               end else if (op_data.is_nak || op_data.is_want_crc) begin
                  if (op_data.is_want_crc) usecrc_in = 1'b1;
                  pos_in = '0; pcan_in = 1'b0; ph_in = PH_SENDING;
               end else timer_in = start_w_ff;
            end else if (ph_ff == PH_REPLY) begin
               if (op_data.is_ack) begin
                  first_in = 1'b0; ph_in = PH_DONE;
               end else begin
                  if (first_ff && op_data.is_want_crc) usecrc_in = 1'b1;
                  pcan_in = op_data.is_can; ph_in = PH_DRAIN; timer_in = drain_w_ff;
               end
            end else if (ph_ff == PH_DRAIN) begin
               if (op_data.is_can && pcan_ff) begin
                  canl_in = 2'd3; ph_in = PH_CANCEL;
               end else begin
                  pcan_in = op_data.is_can; timer_in = drain_w_ff;
               end
            end else if (ph_ff == PH_EOT_WAIT) begin
               if (op_data.is_ack) ph_in = PH_DONE;
               else if (att_ff >= eot_lim_ff) begin
                  canl_in = 2'd3; ph_in = PH_CANCEL;
               end else ph_in = PH_EOT_SEND;
            end
         end
         CMD_TICK: begin
            if (ph_ff == PH_START_ANY || ph_ff == PH_START_NAK || ph_ff == PH_REPLY ||
                ph_ff == PH_DRAIN || ph_ff == PH_EOT_WAIT) begin
               if (timer_ff > 16'd1) timer_in = timer_ff - 16'd1;
               else begin
                  timer_in = '0;
                  if (ph_ff == PH_START_ANY) begin
                     canl_in = 2'd3; ph_in = PH_CANCEL;
                  end else if (ph_ff == PH_START_NAK) begin
                     pos_in = '0; pcan_in = 1'b0; ph_in = PH_SENDING;
                  end else if (ph_ff == PH_EOT_WAIT) begin
                     if (att_ff >= eot_lim_ff) begin
                        canl_in = 2'd3; ph_in = PH_CANCEL;
                     end else ph_in = PH_EOT_SEND;
                  end else if (att_ff >= retry_lim_ff) begin
                     canl_in = 2'd3; ph_in = PH_CANCEL;
                  end else begin
                     att_in = att_ff + 4'd1;
                     pos_in = '0; pcan_in = 1'b0; ph_in = PH_SENDING;
                  end
               end
            end
         end
         default: ;
      endcase
      rsp_in.tx_valid = txv;
      rsp_in.tx_byte = txb;
      rsp_in.crc_mode = usecrc_in;
      unique case (ph_in)
         PH_START_ANY, PH_START_NAK: rsp_in.status = StStart;
         PH_SENDING, PH_EOT_SEND: rsp_in.status = StSending;
         PH_REPLY, PH_DRAIN, PH_EOT_WAIT: rsp_in.status = StReply;
         PH_DONE: rsp_in.status = StDone;
         PH_CANCEL, PH_FAILED: rsp_in.status = StFailed;
         default: rsp_in.status = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (go && op_data.cmd == CMD_LOAD) store[load_ff] <= op_data.byte_in;
      if (go && op_data.cmd == CMD_LOAD && load_ff == off[AW-1:0]) rd_ff <= op_data.byte_in;
      else rd_ff <= store[off[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_lim_ff <= 4'd5; eot_lim_ff <= 4'd5;
         start_w_ff <= 16'd400; reply_w_ff <= 16'd100; drain_w_ff <= 16'd10;
      end else if (csr_write) begin
         case (reg_type'(csr_index))
            REG_BLOCK_RETRY: retry_lim_ff <= csr_data[3:0];
            REG_EOT_LIMIT: eot_lim_ff <= csr_data[3:0];
            REG_START_WAIT: start_w_ff <= csr_data;
            REG_REPLY_WAIT: reply_w_ff <= csr_data;
            REG_DRAIN_WAIT: drain_w_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; load_ff <= '0; pos_ff <= '0; crc_ff <= '0; sum_ff <= '0;
         num_ff <= '0; usecrc_ff <= 1'b0; first_ff <= 1'b1; pcan_ff <= 1'b0;
         att_ff <= '0; canl_ff <= '0; timer_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (go) begin
            ph_ff <= ph_in; load_ff <= load_in; pos_ff <= pos_in; crc_ff <= crc_in;
            sum_ff <= sum_in; num_ff <= num_in; usecrc_ff <= usecrc_in;
            first_ff <= first_in; pcan_ff <= pcan_in; att_ff <= att_in;
            canl_ff <= canl_in; timer_ff <= timer_in;
         end
         if (op_take) rv_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (go) rsp_ff <= rsp_in;
   end

   `XBS_ASSERT_IMPL(a_cancel_count, clock, reset, ph_ff == PH_CANCEL, canl_ff != 2'd0,
      "cancel phase with nothing left to send")
   `XBS_ASSERT_NEXT(a_result_follows, clock, reset, go, rv_ff,
      "accepted command gave no result")
   `XBS_ASSERT_IMPL(a_idle_silent, clock, reset, rv_ff && rsp_ff.status == StIdle,
      !rsp_ff.tx_valid, "byte sent while idle")
endmodule

FILE: design/xmodem_batch_block_sender_core.sv
// An accepted item waits in the front queue; the back part registers its result when it takes the item.
// Throughput: one command per cycle while rsp_stall stays low; one back-end step per command.
// The block store has one write port and one registered read at the next send offset.
// Reset clears all control state and restores register defaults; store contents stay.
// Top level of the XMODEM batch block sender.
module xmodem_batch_block_sender_core import xbs_pkg::*; #(
   parameter int BLOCK_BYTES = BlockBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic op_valid, op_take;
   op_type op_data;

   xbs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .op_valid, .op_take, .op_data
   );

   xbs_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .op_valid, .op_take, .op_data, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

FILE: test/tb_xmodem_batch_block_sender_core.sv
// Self-checking testbench for the XMODEM batch block sender: directed commands, then random block and EOT sessions.
module tb_xmodem_batch_block_sender_core;
   import xbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class xmodem_line_predictor;
      logic [7:0]  store [128];
      logic [6:0]  load_pos;
      logic [7:0]  send_pos;
      phase_type   phase;
      logic [15:0] crc;
      logic [7:0]  sum;
      logic        use_crc, first_blk, prev_can;
      logic [3:0]  attempts;
      logic [15:0] timer;
      logic [7:0]  number;
      logic [1:0]  cans_left;
      logic [3:0]  retry_lim, eot_lim;
      logic [15:0] start_wait, reply_wait, drain_wait;
      rsp_type     expected_rsp [$];
      int          errors;

      function new();
         retry_lim = 4'd5;
         eot_lim = 4'd5;
         start_wait = 16'd400;
         reply_wait = 16'd100;
         drain_wait = 16'd10;
         load_pos = '0;
         send_pos = '0;
         phase = PH_IDLE;
         crc = '0;
         sum = '0;
         use_crc = 1'b0;
         first_blk = 1'b1;
         prev_can = 1'b0;
         attempts = '0;
         timer = '0;
         number = '0;
         cans_left = '0;
         errors = 0;
      endfunction

      function void set_reg(reg_type idx, logic [15:0] value);
         case (idx)
            REG_BLOCK_RETRY: retry_lim = value[3:0];
            REG_EOT_LIMIT: eot_lim = value[3:0];
            REG_START_WAIT: start_wait = value;
            REG_REPLY_WAIT: reply_wait = value;
            REG_DRAIN_WAIT: drain_wait = value;
            default: ;
         endcase
      endfunction

      function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c;
         for (int k = 7; k >= 0; k--) begin
            r = r[15] ? ({r[14:0], b[k]} ^ 16'h1021) : {r[14:0], b[k]};
         end
         return r;
      endfunction

      function void begin_send();
         send_pos = '0;
         prev_can = 1'b0;
         phase = PH_SENDING;
      endfunction

      function void cancel_out();
         cans_left = 2'd3;
         phase = PH_CANCEL;
      endfunction

      function void block_retry();
         if (attempts >= retry_lim) begin
            cancel_out();
         end else begin
            attempts++;
            begin_send();
         end
      endfunction

      function void eot_again();
         if (attempts >= eot_lim) cancel_out();
         else phase = PH_EOT_SEND;
      endfunction

      function logic [7:0] frame_byte();
         logic [7:0] b;
         int p;
         p = send_pos;
         if (p == 0) begin
            crc = '0;
            sum = '0;
            b = ChSoh;
         end else if (p == 1) begin
            b = number;
         end else if (p == 2) begin
            b = ~number;
         end else if (p < 131) begin
            b = store[p - 3];
            crc = crc_step(crc, b);
            sum = sum + b;
         end else if (use_crc && p == 131) begin
            crc = crc_step(crc_step(crc, 8'h00), 8'h00);
            b = crc[15:8];
         end else if (use_crc) begin
            b = crc[7:0];
         end else begin
            b = sum;
         end
         send_pos = 8'(p + 1);
         if (p + 1 >= (use_crc ? 133 : 132)) begin
            phase = PH_REPLY;
            timer = reply_wait;
         end
         return b;
      endfunction

      function logic [2:0] status_of();
         case (phase)
            PH_START_ANY, PH_START_NAK: return StStart;
            PH_SENDING, PH_EOT_SEND: return StSending;
            PH_REPLY, PH_DRAIN, PH_EOT_WAIT: return StReply;
            PH_DONE: return StDone;
            PH_CANCEL, PH_FAILED: return StFailed;
            default: return StIdle;
         endcase
      endfunction

      function void note(req_type r);
         rsp_type e;
         logic free;
         logic [7:0] by;
         e = '0;
         by = r.byte_in;
         free = (phase == PH_IDLE || phase == PH_DONE || phase == PH_FAILED);
         case (cmd_type'(r.command))
            CMD_BEGIN: begin
               use_crc = 1'b0;
               first_blk = 1'b1;
               phase = PH_IDLE;
               cans_left = '0;
            end
            CMD_LOAD: begin
               store[load_pos] = by;
               load_pos++;
            end
            CMD_SEND_BLOCK: if (free) begin
               number = r.block_number;
               attempts = '0;
               load_pos = '0;
               if (r.wait_mode == 2'd1) begin
                  phase = PH_START_ANY;
                  timer = start_wait;
               end else if (r.wait_mode == 2'd2) begin
                  first_blk = 1'b1;
                  phase = PH_START_NAK;
                  timer = start_wait;
               end else begin
                  begin_send();
               end
            end
            CMD_SEND_EOT: if (free) begin
               attempts = '0;
               phase = PH_EOT_SEND;
            end
            CMD_TX_READY: begin
               if (phase == PH_SENDING) begin
                  e.tx_valid = 1'b1;
                  e.tx_byte = frame_byte();
               end else if (phase == PH_EOT_SEND) begin
                  e.tx_valid = 1'b1;
                  e.tx_byte = ChEot;
                  if (attempts < 4'd15) attempts++;
                  phase = PH_EOT_WAIT;
                  timer = reply_wait;
               end else if (phase == PH_CANCEL) begin
                  e.tx_valid = 1'b1;
                  e.tx_byte = ChCan;
                  if (cans_left > 0) cans_left--;
                  if (cans_left == 0) phase = PH_FAILED;
               end
            end
            CMD_RX_BYTE: begin
               if (phase == PH_START_ANY) begin
                  if (by == ChWantCrc) use_crc = 1'b1;
                  begin_send();
               end else if (phase == PH_START_NAK) begin
                  if (by == ChCan) begin
                     cancel_out();
                  end else if (by == ChNak || by == ChWantCrc) begin
                     if (by == ChWantCrc) use_crc = 1'b1;
                     begin_send();
                  end else begin
                     timer = start_wait;
                  end
               end else if (phase == PH_REPLY) begin
                  if (by == ChAck) begin
                     first_blk = 1'b0;
                     phase = PH_DONE;
                  end else begin
                     if (first_blk && by == ChWantCrc) use_crc = 1'b1;
                     prev_can = (by == ChCan);
                     phase = PH_DRAIN;
                     timer = drain_wait;
                  end
               end else if (phase == PH_DRAIN) begin
                  if (by == ChCan && prev_can) begin
                     cancel_out();
                  end else begin
                     prev_can = (by == ChCan);
                     timer = drain_wait;
                  end
               end else if (phase == PH_EOT_WAIT) begin
                  if (by == ChAck) phase = PH_DONE;
                  else eot_again();
               end
            end
            CMD_TICK: begin
               if (phase inside {PH_START_ANY, PH_START_NAK, PH_REPLY, PH_DRAIN, PH_EOT_WAIT})
               begin
                  if (timer > 16'd1) begin
                     timer--;
                  end else begin
                     timer = '0;
                     if (phase == PH_START_ANY) cancel_out();
                     else if (phase == PH_START_NAK) begin_send();
                     else if (phase == PH_EOT_WAIT) eot_again();
                     else block_retry();
                  end
               end
            end
            default: ;
         endcase
         e.status = status_of();
         e.crc_mode = use_crc;
         expected_rsp.push_back(e);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("Result with no item outstanding: %h", a);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (a.tx_valid !== e.tx_valid) begin
            $error("tx_valid: expected %0d, actual %0d", e.tx_valid, a.tx_valid);
            errors++;
         end
         if (a.tx_byte !== e.tx_byte) begin
            $error("tx_byte: expected %h, actual %h", e.tx_byte, a.tx_byte);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status);
            errors++;
         end
         if (a.crc_mode !== e.crc_mode) begin
            $error("crc_mode: expected %0d, actual %0d", e.crc_mode, a.crc_mode);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   xmodem_line_predictor line_model;
   int burst_left;
   int items_sent;
   int stall_left;
   int stall_kind;

   xmodem_batch_block_sender_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
         end
         stall_left--;
         case (stall_kind)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 4) == 0);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) line_model.check(rsp_data);
   end

   task automatic push_item(cmd_type c, logic [7:0] by, logic [7:0] num, logic [1:0] mode);
      req_type r;
      r.command = c;
      r.byte_in = by;
      r.block_number = num;
      r.wait_mode = mode;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      line_model.note(r);
      items_sent++;
   endtask

   task automatic settle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_model.expected_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      line_model.set_reg(idx, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_block();
      for (int i = 0; i < 128; i++) push_item(CMD_LOAD, 8'($urandom_range(0, 255)), 8'h00, 2'd0);
   endtask

   function automatic logic [7:0] line_reply(int ack_weight);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < ack_weight) return ChAck;
      if (pick < ack_weight + 12) return ChNak;
      if (pick < ack_weight + 24) return ChWantCrc;
      if (pick < ack_weight + 40) return ChCan;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic run_session(logic eot);
      int steps;
      int pick;
      if (eot) push_item(CMD_SEND_EOT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         2'd0);
      else push_item(CMD_SEND_BLOCK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)));
      steps = 0;
      while (!(line_model.phase inside {PH_IDLE, PH_DONE, PH_FAILED}) && steps < 1500) begin
         pick = $urandom_range(0, 99);
         steps++;
         if (pick < 2) begin
            push_item(cmd_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
         end else if (line_model.phase inside {PH_SENDING, PH_EOT_SEND, PH_CANCEL}) begin
            if (pick < 92) push_item(CMD_TX_READY, 8'($urandom_range(0, 255)), 8'h00, 2'd0);
            else if (pick < 96) push_item(CMD_TICK, 8'h00, 8'h00, 2'd0);
            else push_item(CMD_RX_BYTE, line_reply(20), 8'h00, 2'd0);
         end else if (line_model.phase inside {PH_START_ANY, PH_START_NAK}) begin
            if (pick < 50) push_item(CMD_TICK, 8'h00, 8'h00, 2'd0);
            else push_item(CMD_RX_BYTE, line_reply(0), 8'h00, 2'd0);
         end else begin
            if (pick < 55) push_item(CMD_TICK, 8'h00, 8'h00, 2'd0);
            else push_item(CMD_RX_BYTE, line_reply(35), 8'h00, 2'd0);
         end
      end
      if (steps >= 1500) push_item(CMD_BEGIN, 8'h00, 8'h00, 2'd0);
   endtask

   task automatic pick_settings(logic wide);
      settle();
      write_reg(REG_BLOCK_RETRY, 16'($urandom_range(0, 15)));
      write_reg(REG_EOT_LIMIT, 16'($urandom_range(1, 15)));
      write_reg(REG_START_WAIT, wide ? 16'hFFFF : 16'($urandom_range(1, 6)));
      write_reg(REG_REPLY_WAIT, wide ? 16'hFFFF : 16'($urandom_range(1, 6)));
      write_reg(REG_DRAIN_WAIT, wide ? 16'hFFFF : 16'($urandom_range(1, 4)));
   endtask

   initial begin
      int round;
      line_model = new();
      burst_left = 0;
      items_sent = 0;
      stall_left = 0;
      stall_kind = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every store entry is written before any block goes out.
      for (int i = 0; i < 128; i++) begin
         push_item(CMD_LOAD, (i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'hFF : 8'h5A), 8'h00, 2'd0);
      end
      push_item(CMD_NONE, 8'hFF, 8'hFF, 2'd3);
      push_item(CMD_TX_READY, 8'h00, 8'h00, 2'd0);
      push_item(CMD_RX_BYTE, ChAck, 8'h00, 2'd0);
      push_item(CMD_TICK, 8'h00, 8'h00, 2'd0);
      push_item(CMD_SEND_EOT, 8'h00, 8'h00, 2'd0);
      push_item(CMD_SEND_BLOCK, 8'h00, 8'h01, 2'd0);
      push_item(CMD_TX_READY, 8'h00, 8'h00, 2'd0);
      push_item(CMD_RX_BYTE, ChNak, 8'h00, 2'd0);
      push_item(CMD_TX_READY, 8'h00, 8'h00, 2'd0);
      push_item(CMD_RX_BYTE, ChAck, 8'h00, 2'd0);
      push_item(CMD_SEND_BLOCK, 8'h00, 8'hFF, 2'd3);
      push_item(CMD_TX_READY, 8'h00, 8'h00, 2'd0);
      push_item(CMD_SEND_EOT, 8'h00, 8'h00, 2'd0);
      push_item(CMD_BEGIN, 8'h00, 8'h00, 2'd0);

      pick_settings(1'b1);
      write_reg(REG_BLOCK_RETRY, 16'd0);
      run_session(1'b0);
      run_session(1'b1);
      round = 0;
      while (items_sent < 1250) begin
         if (round % 4 == 0) begin
            pick_settings(1'b0);
            if (round % 8 == 0) write_reg(REG_BLOCK_RETRY, ($urandom_range(0, 1) != 0) ? 16'd15 : 16'd0);
            if (round % 12 == 0) write_reg(REG_EOT_LIMIT, ($urandom_range(0, 1) != 0) ? 16'd15 : 16'd1);
         end
         if ($urandom_range(0, 4) == 0) push_item(CMD_BEGIN, 8'h00, 8'h00, 2'd0);
         if ($urandom_range(0, 2) == 0) load_block();
         run_session($urandom_range(0, 3) == 0);
         round++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (line_model.errors == 0 && line_model.expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+design
design/xbs_pkg.sv
design/xbs_front.sv
design/xbs_back.sv
design/xmodem_batch_block_sender_core.sv
test/tb_xmodem_batch_block_sender_core.sv
